// ===== sv/rotated_strip_bilinear_sampler_assert.svh =====
// Assertion macros for the rotated strip bilinear sampler checkers.
// Used by files that take this header by include; no other dependencies.
`ifndef ROTATED_STRIP_BILINEAR_SAMPLER_ASSERT_SVH
`define ROTATED_STRIP_BILINEAR_SAMPLER_ASSERT_SVH

// Property holds in the same cycle as its trigger.
`define RSBS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Property holds in the cycle after its trigger.
`define RSBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rsbs_pkg.sv =====
// Shared constants and types for the rotated strip bilinear sampler.
// No dependencies.
package rsbs_pkg;
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int CHANNELS   = 4;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int CH_W = 2;
  // Each of the four parity banks holds every other column and row.
  localparam int BANK_AW    = CH_W + (XW - 1) + (YW - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W      = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_COS          = 3'd4,
    CFG_SIN          = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;
endpackage

// ===== sv/rsbs_in_if.sv =====
// Input channel of the sampler: handshake plus one item's fields.
// Depends on rsbs_pkg.
interface rsbs_in_if;
  import rsbs_pkg::*;
  logic                valid;
  logic                ready;
  logic                operation;
  logic [1:0]          channel;
  logic [8:0]          src_x;
  logic [8:0]          src_y;
  logic [7:0]          pixel_value;
  logic signed [11:0]  offset_x;
  logic signed [11:0]  offset_y;
  modport source (output valid, operation, channel, src_x, src_y, pixel_value,
                  offset_x, offset_y, input ready);
  modport sink   (input valid, operation, channel, src_x, src_y, pixel_value,
                  offset_x, offset_y, output ready);
endinterface

// ===== sv/rsbs_out_if.sv =====
// Result channel of the sampler: handshake plus one result's fields.
// No dependencies.
interface rsbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_value;
  logic       in_bounds;
  modport source (output valid, sample_value, in_bounds, input ready);
  modport sink   (input valid, sample_value, in_bounds, output ready);
endinterface

// ===== sv/rsbs_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module rsbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/rotated_strip_bilinear_sampler.sv =====
// Rotated strip bilinear sampler top level: config registers, pipeline, banked image store.
// Depends on rsbs_pkg, rsbs_in_if, rsbs_out_if and rsbs_ram.
//
// Usage: items arrive on in_s. A write item (operation 0) stores one 8-bit
// pixel of one channel and returns nothing. A sample item (operation 1)
// rotates (offset_x, offset_y) by cos/sin in Q1.14, adds the centre given in
// half pixels, and returns one result on out_s: the truncated bilinear blend
// of the four neighbours, or zero with in_bounds low when the position or its
// right/lower neighbours fall outside the image.
// Throughput is one item per cycle while out_s is not stalled. A sample result appears on
// out_s after passing seven registers: input, multiply, sum, image read, weight multiply,
// weighted pixel multiply, output.
// The image is split into four parity banks (even/odd column by even/odd row),
// so the four neighbours come from four RAMs in one read cycle.
// Writes reach the banks at the same stage as reads, which keeps the order of
// writes and samples as they were accepted.
// When out_s is stalled with a result waiting, the whole pipeline holds and
// in_s.ready falls; nothing is lost or repeated. Reset clears the valid bits
// and loads the configuration defaults; the image store is not cleared and
// every pixel must be written before it is sampled.
module rotated_strip_bilinear_sampler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rsbs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rsbs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  rsbs_in_if.sink                           in_s,
  rsbs_out_if.source                        out_s
);
  import rsbs_pkg::*;

  // Configuration registers. Writes take effect at once; the user must make them
  // only while no item is in flight, which the block itself does not enforce.
  logic [9:0]         width_q, height_q, cx_q, cy_q;
  logic signed [15:0] cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 10'd512;
      height_q <= 10'd512;
      cx_q     <= '0;
      cy_q     <= '0;
      cos_q    <= 16'sd16384;
      sin_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[9:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[9:0];
        CFG_CENTER_X:     cx_q     <= cfg_wdata_i[9:0];
        CFG_CENTER_Y:     cy_q     <= cfg_wdata_i[9:0];
        CFG_COS:          cos_q    <= $signed(cfg_wdata_i);
        CFG_SIN:          sin_q    <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it holds only while a result waits.
  logic out_valid_q;
  logic adv;
  assign adv        = !out_valid_q || out_s.ready;
  assign in_s.ready = adv;

  // Valid bits.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // Stage 1: registered input item.
  logic               op1_q;
  logic [1:0]         ch1_q;
  logic [8:0]         wx1_q, wy1_q;
  logic [7:0]         pix1_q;
  logic signed [11:0] lx1_q, ly1_q;

  // Stage 2: rotation products.
  logic               op2_q;
  logic [1:0]         ch2_q;
  logic [8:0]         wx2_q, wy2_q;
  logic [7:0]         pix2_q;
  logic signed [27:0] lc2_q, ls2_q, yc2_q, ys2_q;

  // Stage 3: position in Q.14.
  logic                   op3_q;
  logic [1:0]             ch3_q;
  logic [8:0]             wx3_q, wy3_q;
  logic [7:0]             pix3_q;
  logic signed [POS_W-1:0] px3_q, py3_q;

  // Stage 4: RAM data plus fractions.
  logic       op4_q, ok4_q, x04_q, y04_q;
  logic [7:0] fx4_q, fy4_q;

  // Stage 5: weights and ordered neighbours.
  logic        op5_q, ok5_q;
  logic [16:0] w5_q [4];
  logic [7:0]  p5_q [4];

  // Stage 6: weighted pixels.
  logic        op6_q, ok6_q;
  logic [24:0] m6_q [4];

  // Output register.
  logic [7:0] out_val_q;
  logic       out_inb_q;

  // Control valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_s.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      out_valid_q <= v6_q && (op6_q == OP_SAMPLE);
    end
  end

  // Stage 3 address and bounds logic.
  logic [9:0]  w_cl, h_cl;
  logic [15:0] ix3, iy3;
  logic [16:0] ix3_p1, iy3_p1;
  logic        ok3, wr_ok3;
  logic [XW-2:0] xb_lo, xb_hi;
  logic [YW-2:0] yb_lo, yb_hi;

  assign w_cl   = (32'(width_q) > MAX_WIDTH) ? 10'(MAX_WIDTH) : width_q;
  assign h_cl   = (32'(height_q) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : height_q;
  assign ix3    = px3_q[29:14];
  assign iy3    = py3_q[29:14];
  assign ix3_p1 = 17'(ix3) + 17'd1;
  assign iy3_p1 = 17'(iy3) + 17'd1;
  assign ok3    = (32'(ch3_q) < CHANNELS) && !px3_q[POS_W-1] && !py3_q[POS_W-1]
                  && (ix3_p1 < 17'(w_cl)) && (iy3_p1 < 17'(h_cl));
  assign wr_ok3 = (32'(ch3_q) < CHANNELS) && (32'(wx3_q) < MAX_WIDTH)
                  && (32'(wy3_q) < MAX_HEIGHT);
  // Bank column for banks whose parity is above or below the left column.
  assign xb_hi  = ix3[XW-1:1];
  assign xb_lo  = (XW-1)'(ix3[XW-1:1] + (XW-1)'(ix3[0]));
  assign yb_hi  = iy3[YW-1:1];
  assign yb_lo  = (YW-1)'(iy3[YW-1:1] + (YW-1)'(iy3[0]));

  // Four parity banks, index by = row parity, bx = column parity.
  logic [7:0] rd [4];
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = 1'(b % 2);
    localparam logic BY = 1'(b / 2);
    logic [BANK_AW-1:0] raddr, waddr;
    logic               we;
    assign raddr = {ch3_q, (BY ? yb_hi : yb_lo), (BX ? xb_hi : xb_lo)};
    assign waddr = {ch3_q, wy3_q[YW-1:1], wx3_q[XW-1:1]};
    assign we    = adv && v3_q && (op3_q == OP_WRITE) && wr_ok3
                   && (wx3_q[0] == BX) && (wy3_q[0] == BY);
    rsbs_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (pix3_q),
      .re_i    (adv),
      .raddr_i (raddr),
      .rdata_o (rd[b])
    );
  end

  // Stage 4 weights: neighbours in order 00, 01 (right), 10 (below), 11.
  logic [8:0]  gx, gy;
  logic [16:0] w4 [4];
  logic [7:0]  p4 [4];
  assign gx    = 9'd256 - 9'(fx4_q);
  assign gy    = 9'd256 - 9'(fy4_q);
  assign w4[0] = 17'(gx * gy);
  assign w4[1] = 17'(9'(fx4_q) * gy);
  assign w4[2] = 17'(gx * 9'(fy4_q));
  assign w4[3] = 17'(fx4_q * fy4_q);
  assign p4[0] = rd[{y04_q, x04_q}];
  assign p4[1] = rd[{y04_q, !x04_q}];
  assign p4[2] = rd[{!y04_q, x04_q}];
  assign p4[3] = rd[{!y04_q, !x04_q}];

  logic [26:0] acc6;
  assign acc6 = 27'(m6_q[0]) + 27'(m6_q[1]) + 27'(m6_q[2]) + 27'(m6_q[3]);

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q  <= in_s.operation;
      ch1_q  <= in_s.channel;
      wx1_q  <= in_s.src_x;
      wy1_q  <= in_s.src_y;
      pix1_q <= in_s.pixel_value;
      lx1_q  <= in_s.offset_x;
      ly1_q  <= in_s.offset_y;

      op2_q  <= op1_q;
      ch2_q  <= ch1_q;
      wx2_q  <= wx1_q;
      wy2_q  <= wy1_q;
      pix2_q <= pix1_q;
      lc2_q  <= 28'(lx1_q * cos_q);
      ls2_q  <= 28'(lx1_q * sin_q);
      yc2_q  <= 28'(ly1_q * cos_q);
      ys2_q  <= 28'(ly1_q * sin_q);

      op3_q  <= op2_q;
      ch3_q  <= ch2_q;
      wx3_q  <= wx2_q;
      wy3_q  <= wy2_q;
      pix3_q <= pix2_q;
      px3_q  <= POS_W'(lc2_q) - POS_W'(ys2_q) + $signed(POS_W'({cx_q, 13'd0}));
      py3_q  <= POS_W'(ls2_q) + POS_W'(yc2_q) + $signed(POS_W'({cy_q, 13'd0}));

      op4_q  <= op3_q;
      ok4_q  <= ok3;
      fx4_q  <= px3_q[13:6];
      fy4_q  <= py3_q[13:6];
      x04_q  <= ix3[0];
      y04_q  <= iy3[0];

      op5_q  <= op4_q;
      ok5_q  <= ok4_q;
      w5_q   <= w4;
      p5_q   <= p4;

      op6_q  <= op5_q;
      ok6_q  <= ok5_q;
      for (int k = 0; k < 4; k++) begin
        m6_q[k] <= 25'(w5_q[k] * p5_q[k]);
      end

      out_val_q <= ok6_q ? acc6[23:16] : 8'd0;
      out_inb_q <= ok6_q;
    end
  end

  assign out_s.valid        = out_valid_q;
  assign out_s.sample_value = out_val_q;
  assign out_s.in_bounds    = out_inb_q;
endmodule

// ===== sv/rsbs_checker.sv =====
// Port-level checker for the rotated strip bilinear sampler and its bind.
// Depends on rotated_strip_bilinear_sampler_assert.svh.
`include "rotated_strip_bilinear_sampler_assert.svh"

module rsbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_value_i,
  input logic       out_inb_i
);
  // A waiting result stays offered.
  `RSBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  // An item outside the image carries a zero value.
  `RSBS_ASSERT_NOW(a_oob_zero, clk_i, rst_ni, out_valid_i && !out_inb_i, out_value_i == 8'd0, "out of bounds result not zero")
  // A stalled result blocks the input.
  `RSBS_ASSERT_NOW(a_stall_blocks, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i, "input taken while output stalled")
  // With no result waiting the block takes items.
  `RSBS_ASSERT_NOW(a_free_ready, clk_i, rst_ni, !out_valid_i, in_ready_i, "input refused with empty output")
endmodule

bind rotated_strip_bilinear_sampler rsbs_checker u_rsbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_s.ready),
  .out_valid_i (out_s.valid),
  .out_ready_i (out_s.ready),
  .out_value_i (out_s.sample_value),
  .out_inb_i   (out_s.in_bounds)
);

// ===== tb/rsbs_sample_checker.sv =====
// Checker for the rotated strip bilinear sampler: mirrors the image store and the
// configuration, predicts each sample result and compares it. Depends on rsbs_pkg.
module rsbs_sample_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rsbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rsbs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            in_operation_i,
  input  logic [1:0]                      in_channel_i,
  input  logic [8:0]                      in_src_x_i,
  input  logic [8:0]                      in_src_y_i,
  input  logic [7:0]                      in_pixel_i,
  input  logic signed [11:0]              in_offset_x_i,
  input  logic signed [11:0]              in_offset_y_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [7:0]                      out_sample_i,
  input  logic                            out_in_bounds_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import rsbs_pkg::*;

  typedef struct packed {
    logic [7:0] sample_value;
    logic       in_bounds;
  } sample_t;

  logic [7:0]  image_mirror [int];
  logic [9:0]  width_q, height_q, cx2_q, cy2_q;
  logic signed [15:0] cos_q, sin_q;
  sample_t     expected_samples [$];

  assign pending_o = expected_samples.size();

  function automatic int pix_key(int ch, int y, int x);
    return (ch * MAX_HEIGHT + y) * MAX_WIDTH + x;
  endfunction

  function automatic logic [7:0] pix_at(int key);
    return image_mirror.exists(key) ? image_mirror[key] : 8'd0;
  endfunction

  function automatic sample_t interpolate(logic [1:0] ch, logic signed [11:0] lx,
                                          logic signed [11:0] ly);
    longint px, py, ix, iy, fx, fy, acc, w, h;
    int key;
    sample_t r;
    r = '0;
    w = (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
    h = (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;
    px = longint'(lx) * cos_q - longint'(ly) * sin_q + longint'(cx2_q) * 8192;
    py = longint'(lx) * sin_q + longint'(ly) * cos_q + longint'(cy2_q) * 8192;
    if (ch >= CHANNELS || px < 0 || py < 0) return r;
    ix = px >>> 14;
    iy = py >>> 14;
    if (ix + 1 >= w || iy + 1 >= h) return r;
    fx = (px >>> 6) & 255;
    fy = (py >>> 6) & 255;
    key = pix_key(ch, iy, ix);
    acc = (256 - fx) * (256 - fy) * pix_at(key) + fx * (256 - fy) * pix_at(key + 1)
        + (256 - fx) * fy * pix_at(key + MAX_WIDTH)
        + fx * fy * pix_at(key + MAX_WIDTH + 1);
    r.sample_value = acc >> 16;
    r.in_bounds = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t got, want;
    if (!rst_ni) begin
      width_q <= 10'd512; height_q <= 10'd512;
      cx2_q <= '0; cy2_q <= '0;
      cos_q <= 16'sd16384; sin_q <= '0;
      fail_count_o <= 0;
      expected_samples.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_IMAGE_WIDTH:  width_q <= cfg_wdata_i[9:0];
          CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[9:0];
          CFG_CENTER_X:     cx2_q <= cfg_wdata_i[9:0];
          CFG_CENTER_Y:     cy2_q <= cfg_wdata_i[9:0];
          CFG_COS:          cos_q <= cfg_wdata_i;
          CFG_SIN:          sin_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      // Compare the output before queuing this edge's sample, so the queue order
      // is the acceptance order.
      if (out_valid_i && out_ready_i) begin
        got.sample_value = out_sample_i;
        got.in_bounds = out_in_bounds_i;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result value=%0d in_bounds=%0b", $time,
                   got.sample_value, got.in_bounds);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_samples.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected value=%0d in_bounds=%0b, got value=%0d in_bounds=%0b",
                     $time, want.sample_value, want.in_bounds, got.sample_value,
                     got.in_bounds);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (op_e'(in_operation_i) == OP_WRITE)
          image_mirror[pix_key(in_channel_i, in_src_y_i, in_src_x_i)] = in_pixel_i;
        else
          expected_samples.insert(expected_samples.size(),
                                  interpolate(in_channel_i, in_offset_x_i, in_offset_y_i));
      end
    end
  end
endmodule

// ===== tb/rotated_strip_bilinear_sampler_tb.sv =====
// Top of the sampler testbench: clock, reset, configuration phases and stimulus.
// Depends on rsbs_pkg, rsbs_in_if, rsbs_out_if, rsbs_sample_checker and the block.
module rotated_strip_bilinear_sampler_tb;
  import rsbs_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int   fail_count, pending;
  int   send_idle_pct, recv_idle_pct;
  int   items_sent;

  // Pixels are written inside this window, but for two directed store corners, and
  // every sample lands inside it or out of bounds, so no unwritten pixel is ever read.
  localparam int WIN = 12;

  rsbs_in_if  in_ch ();
  rsbs_out_if out_ch ();

  rotated_strip_bilinear_sampler uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .in_s(in_ch.sink), .out_s(out_ch.source)
  );

  rsbs_sample_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
    .in_operation_i(in_ch.operation), .in_channel_i(in_ch.channel),
    .in_src_x_i(in_ch.src_x), .in_src_y_i(in_ch.src_y),
    .in_pixel_i(in_ch.pixel_value), .in_offset_x_i(in_ch.offset_x),
    .in_offset_y_i(in_ch.offset_y), .out_valid_i(out_ch.valid),
    .out_ready_i(out_ch.ready), .out_sample_i(out_ch.sample_value),
    .out_in_bounds_i(out_ch.in_bounds), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The receiver stalls at random; the percentage changes with the phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hands one item to the block and holds it until it is accepted. Valid stays
  // high across back-to-back items; an idle gap lowers it only between items.
  task automatic send_item(logic op, logic [1:0] ch, logic [8:0] sx, logic [8:0] sy,
                           logic [7:0] pv, logic signed [11:0] ox,
                           logic signed [11:0] oy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.channel <= ch;
    in_ch.src_x <= sx;
    in_ch.src_y <= sy;
    in_ch.pixel_value <= pv;
    in_ch.offset_x <= ox;
    in_ch.offset_y <= oy;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_pixel(int ch, int x, int y, int v);
    send_item(OP_WRITE, 2'(ch), 9'(x), 9'(y), 8'(v), 12'($urandom), 12'($urandom));
  endtask

  task automatic sample_at(int ch, int ox, int oy);
    send_item(OP_SAMPLE, 2'(ch), 9'($urandom), 9'($urandom), 8'($urandom), 12'(ox),
              12'(oy));
  endtask

  // Lets the pipeline drain: every expected result has arrived and the writes
  // still in flight have reached the store.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int cx2, int cy2, int c, int s);
    write_cfg(CFG_IMAGE_WIDTH, 16'(w));
    write_cfg(CFG_IMAGE_HEIGHT, 16'(h));
    write_cfg(CFG_CENTER_X, 16'(cx2));
    write_cfg(CFG_CENTER_Y, 16'(cy2));
    write_cfg(CFG_COS, 16'(c));
    write_cfg(CFG_SIN, 16'(s));
  endtask

  // A random sample: mostly near the centre with offsets that stay in or near
  // the image, sometimes wild offsets; any channel.
  task automatic random_sample();
    if ($urandom_range(3) == 0)
      sample_at($urandom_range(3), $urandom, $urandom);
    else
      sample_at($urandom_range(3), $signed($urandom_range(16)) - 8,
                $signed($urandom_range(16)) - 8);
  endtask

  task automatic random_phase(int n);
    repeat (n) begin
      if ($urandom_range(3) == 0)
        write_pixel($urandom_range(3), $urandom_range(WIN - 1), $urandom_range(WIN - 1),
                    $urandom);
      else
        random_sample();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_IMAGE_WIDTH;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.channel = '0;
    in_ch.src_x = '0;
    in_ch.src_y = '0;
    in_ch.pixel_value = '0;
    in_ch.offset_x = '0;
    in_ch.offset_y = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the sampling window in every channel so all reads hit written data.
    // Writes outside the window target the store edges and are never read back.
    for (int ch = 0; ch < CHANNELS; ch++)
      for (int y = 0; y < WIN; y++)
        for (int x = 0; x < WIN; x++)
          write_pixel(ch, x, y, (ch == 0 && x == 0 && y == 0) ? 255 : $urandom);

    // Directed: store corners, pixel extremes, identity and rotated sampling.
    write_pixel(3, 511, 511, 8'hff);
    write_pixel(0, 511, 0, 8'h00);
    sample_at(0, 0, 0);
    sample_at(3, WIN - 2, WIN - 2);
    sample_at(1, WIN - 2, 3);
    sample_at(2, -1, 0);
    sample_at(0, 2047, 2047);
    sample_at(0, -2048, -2048);
    drain();
    // Tiny image: everything is out of bounds.
    set_geometry(1, 1, 0, 0, 16384, 0);
    sample_at(0, 0, 0);
    sample_at(1, 1, 1);
    drain();
    // Oversized registers are clamped to the store size; negative trig extremes.
    set_geometry(1023, 1023, 12, 12, -16384, 16384);
    sample_at(0, 5, 3);
    sample_at(2, -3, 2);
    sample_at(0, 0, 0);
    sample_at(0, 2, 1);
    drain();
    // Trig out of range, used as given.
    set_geometry(WIN, WIN, 10, 12, 16'h7fff, 16'h8000);
    sample_at(1, 0, 0);
    sample_at(2, 0, 1);
    sample_at(3, 1, 0);
    drain();
    // Centre at 1022 half pixels lands far outside the window.
    set_geometry(512, 512, 1022, 1022, 16384, 0);
    sample_at(0, 0, 0);
    sample_at(0, -1000, -1000);
    drain();

    // Random phases over several rotations; idling changes between phases.
    send_idle_pct = 20; recv_idle_pct = 48;
    set_geometry(WIN, WIN, 11, 11, 11585, 11585);
    random_phase(120);
    drain();
    send_idle_pct = 48; recv_idle_pct = 20;
    set_geometry(WIN - 3, WIN, 8, 13, -13000, 9900);
    random_phase(80);
    drain();
    set_geometry(2, 2, 1, 1, 4000, -15000);
    random_phase(50);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_geometry(WIN, WIN - 1, 12, 10, 16384, -16384);
    random_phase(100);
    drain();

    // Allow a last window of slack for anything unexpected to show up.
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
